// File: rtl/dgsp_pkg.sv
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants for the dense graph shortest path engine.
// ----------------------------------------------------------------------------
package dgsp_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam int ROW_W      = 4;
  localparam int COL_W      = 4;
  localparam int WEIGHT_W   = 16;
  localparam int VERTEX_W   = 4;
  localparam int DIST_W     = 20;
  localparam int VC_W       = 5;
  localparam int SRC_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 2'd1;

  localparam logic [VC_W-1:0]  VERTEX_COUNT_RST  = 5'd16;
  localparam logic [SRC_W-1:0] SOURCE_VERTEX_RST = 4'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_MARK,
    ST_RELAX,
    ST_ROUND,
    ST_OUT_READ,
    ST_OUT_LOAD,
    ST_OUT_HOLD
  } state_t;

  typedef struct packed {
    logic write_entry;
    logic init;
    logic scan;
    logic mark;
    logic relax;
    logic next_round;
    logic out_load;
    logic out_take;
  } dgsp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic best_reach;
    logic round_last;
    logic out_last;
    logic out_valid;
  } dgsp_status_t;

endpackage

// File: rtl/dgsp_ctrl.sv
// ----------------------------------------------------------------------------
// dgsp_ctrl
// Sequencer: loads matrix entries, steps the select and relax sweeps of each
// round, then hands results out one vertex at a time.
// ----------------------------------------------------------------------------
module dgsp_ctrl import dgsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         final_entry,
  input  logic         out_stall,
  input  dgsp_status_t status,
  output logic         in_stall,
  output dgsp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_take;

  assign out_take = status.out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && final_entry) state_next = ST_INIT;
      end
      ST_INIT:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.sweep_done) state_next = ST_MARK;
      end
      ST_MARK: begin
        state_next = status.best_reach ? ST_RELAX : ST_ROUND;
      end
      ST_RELAX: begin
        if (status.sweep_done) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = status.round_last ? ST_OUT_READ : ST_SCAN;
      end
      ST_OUT_READ: state_next = ST_OUT_LOAD;
      ST_OUT_LOAD: state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (out_take) state_next = status.out_last ? ST_IDLE : ST_OUT_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall        = 1'b0;
        cmd.write_entry = in_valid;
      end
      ST_INIT:     cmd.init = 1'b1;
      ST_SCAN:     cmd.scan = !status.sweep_done;
      ST_MARK:     cmd.mark = 1'b1;
      ST_RELAX:    cmd.relax = !status.sweep_done;
      ST_ROUND:    cmd.next_round = 1'b1;
      ST_OUT_READ: cmd = '0;
      ST_OUT_LOAD: cmd.out_load = 1'b1;
      ST_OUT_HOLD: cmd.out_take = out_take;
      default:     cmd = '0;
    endcase
  end

endmodule

// File: rtl/dgsp_datapath.sv
// ----------------------------------------------------------------------------
// dgsp_datapath
// Weight and distance memories, visit/reach flags, sweep counters, the
// min-select compare, the relax adder and the result register.
// ----------------------------------------------------------------------------
module dgsp_datapath import dgsp_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  dgsp_cmd_t           cmd,
  output dgsp_status_t        status,
  input  logic [VC_W-1:0]     vertex_count,
  input  logic [SRC_W-1:0]    source_vertex,
  input  logic [ROW_W-1:0]    row,
  input  logic [COL_W-1:0]    col,
  input  logic [WEIGHT_W-1:0] weight,
  output logic                out_valid,
  output logic [VERTEX_W-1:0] vertex,
  output logic [DIST_W-1:0]   distance,
  output logic                reachable,
  output logic                final_result
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int WA = 2 * VW;
  localparam int DW = WEIGHT_BITS + VW;
  localparam int CW = (DW > DIST_W) ? DW : DIST_W;

  logic [WEIGHT_BITS-1:0] wmem [2**WA];
  logic [DW-1:0]          dmem [MAX_VERTICES];

  logic [WEIGHT_BITS-1:0] w_rd;
  logic [DW-1:0]          dist_rd;

  logic [NW-1:0]           n;
  logic                    src_ok;
  logic [VW-1:0]           src_idx;
  logic [NW-1:0]           cnt;
  logic [VW-1:0]           cnt_idx;
  logic                    cnt_live;
  logic [NW-1:0]           round;
  logic                    pend_valid;
  logic [VW-1:0]           pend_idx;
  logic                    have;
  logic [VW-1:0]           best;
  logic                    best_reach;
  logic [DW-1:0]           best_d;
  logic [MAX_VERTICES-1:0] reach;
  logic [MAX_VERTICES-1:0] done;

  logic                    entry_ok;
  logic                    cand_reach;
  logic                    take;
  logic [DW-1:0]           sum;
  logic                    upd;
  logic                    d_we;
  logic [VW-1:0]           d_wa;
  logic [DW-1:0]           d_wd;
  logic [CW-1:0]           d_ext;
  logic [DIST_W-1:0]       d_sat;

  always_comb begin
    if (vertex_count < 5'd2) begin
      n = NW'(2);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n = NW'(MAX_VERTICES);
    end else begin
      n = NW'(vertex_count);
    end
  end

  assign src_ok   = 32'(source_vertex) < 32'(n);
  assign src_idx  = VW'(source_vertex);
  assign cnt_idx  = cnt[VW-1:0];
  assign cnt_live = cnt < n;
  assign entry_ok = (32'(row) < MAX_VERTICES) && (32'(col) < MAX_VERTICES);

  // min-select: unreachable counts as infinite, ties go to the higher index
  assign cand_reach = reach[pend_idx];
  always_comb begin
    if (!have) begin
      take = 1'b1;
    end else if (cand_reach != best_reach) begin
      take = cand_reach;
    end else begin
      take = !cand_reach || (dist_rd <= best_d);
    end
  end

  assign sum = best_d + DW'(w_rd);
  assign upd = !done[pend_idx] && (w_rd != '0) && (!reach[pend_idx] || (sum < dist_rd));

  assign d_we = (cmd.init && src_ok) || (cmd.relax && pend_valid && upd);
  assign d_wa = cmd.init ? src_idx : pend_idx;
  assign d_wd = cmd.init ? '0 : sum;

  assign d_ext = CW'(dist_rd);
  assign d_sat = (d_ext > CW'(DIST_MAX)) ? DIST_MAX : DIST_W'(d_ext);

  always_ff @(posedge clk) begin
    if (cmd.write_entry && entry_ok) begin
      wmem[{VW'(row), VW'(col)}] <= WEIGHT_BITS'(weight);
    end
    w_rd <= wmem[{best, cnt_idx}];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_wa] <= d_wd;
    end
    dist_rd <= dmem[cnt_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      round      <= '0;
      pend_valid <= 1'b0;
      have       <= 1'b0;
      reach      <= '0;
      done       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.init) begin
        reach      <= src_ok ? (MAX_VERTICES'(1) << src_idx) : '0;
        done       <= '0;
        cnt        <= '0;
        round      <= '0;
        have       <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (cmd.scan || cmd.relax) begin
        pend_valid <= cnt_live;
        if (cnt_live) cnt <= cnt + NW'(1);
      end
      if (cmd.scan && pend_valid && !done[pend_idx] && take) begin
        have <= 1'b1;
      end
      if (cmd.relax && pend_valid && upd) begin
        reach[pend_idx] <= 1'b1;
      end
      if (cmd.mark) begin
        done[best] <= 1'b1;
        cnt        <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.next_round) begin
        round <= round + NW'(1);
        cnt   <= '0;
        have  <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end
      if (cmd.out_take) begin
        out_valid <= 1'b0;
        cnt       <= cnt + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.scan || cmd.relax) && cnt_live) begin
      pend_idx <= cnt_idx;
    end
    if (cmd.scan && pend_valid && !done[pend_idx] && take) begin
      best       <= pend_idx;
      best_reach <= cand_reach;
      best_d     <= dist_rd;
    end
    if (cmd.out_load) begin
      vertex       <= VERTEX_W'(cnt_idx);
      reachable    <= reach[cnt_idx];
      distance     <= reach[cnt_idx] ? d_sat : '0;
      final_result <= (cnt + NW'(1)) == n;
    end
  end

  assign status.sweep_done = !cnt_live && !pend_valid;
  assign status.best_reach = best_reach;
  assign status.round_last = (round + NW'(2)) == n;
  assign status.out_last   = (cnt + NW'(1)) == n;
  assign status.out_valid  = out_valid;

endmodule

// File: rtl/dense_graph_shortest_paths.sv
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths
// Adjacency-matrix Dijkstra: matrix entries stream into a weight memory;
// the entry marked final starts a run and one result per vertex comes out.
// ----------------------------------------------------------------------------
//  channel  signals                                     direction
//  in       in_valid/in_stall, row col weight final_entry  in, stall out
//  out      out_valid/out_stall, vertex distance reachable
//           final_result                                out, stall in
//  cfg      cfg_valid/cfg_ready, cfg_index cfg_data     in, ready out
//
//  Matrix entries are accepted while idle. After the final entry a run does
//  select and relax sweeps over the single-port distance memory (one vertex
//  per cycle for select and relax), then each result passes the read, load
//  and hold states and waits out any out_stall time. in_stall is high from
//  the final entry until the last result is taken. Reset is synchronous.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths import dgsp_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ROW_W-1:0]      row,
  input  logic [COL_W-1:0]      col,
  input  logic [WEIGHT_W-1:0]   weight,
  input  logic                  final_entry,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VERTEX_W-1:0]   vertex,
  output logic [DIST_W-1:0]     distance,
  output logic                  reachable,
  output logic                  final_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VC_W-1:0]  vertex_count;
  logic [SRC_W-1:0] source_vertex;
  dgsp_cmd_t        cmd;
  dgsp_status_t     status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VERTEX_COUNT_RST;
      source_vertex <= SOURCE_VERTEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data[VC_W-1:0];
        REG_SOURCE_VERTEX: source_vertex <= cfg_data[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  dgsp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .final_entry (final_entry),
    .out_stall   (out_stall),
    .status      (status),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  dgsp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .vertex_count  (vertex_count),
    .source_vertex (source_vertex),
    .row           (row),
    .col           (col),
    .weight        (weight),
    .out_valid     (out_valid),
    .vertex        (vertex),
    .distance      (distance),
    .reachable     (reachable),
    .final_result  (final_result)
  );

endmodule

// File: dv/tb_dense_graph_shortest_paths.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_graph_shortest_paths
// Self-checking bench for the adjacency-matrix shortest path engine. Matrix
// entries stream in from a queue, and every final entry triggers a local
// Dijkstra solve over a mirror of the weight memory and the registers. Each
// per-vertex result from the block is checked in order against that solve.
// Directed runs cover register extremes, unknown register indexes, an
// out-of-range source, tie breaks, unreachable vertices and the longest
// possible path. Random runs with random idling and a long output hold follow.
// ----------------------------------------------------------------------------
module tb_dense_graph_shortest_paths;
  import dgsp_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 16;
  localparam int NV           = DEF_MAX_VERTICES;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } entry_t;

  typedef struct {
    logic [VERTEX_W-1:0] vertex;
    logic [DIST_W-1:0]   span;
    logic                reach;
    logic                last;
  } path_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [ROW_W-1:0]      row         = '0;
  logic [COL_W-1:0]      col         = '0;
  logic [WEIGHT_W-1:0]   weight      = '0;
  logic                  final_entry = 1'b0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [VERTEX_W-1:0]   vertex;
  logic [DIST_W-1:0]     distance;
  logic                  reachable;
  logic                  final_result;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_VERTEX_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  entry_t entry_q[$];
  path_t  path_q[$];

  logic [WEIGHT_W-1:0] weight_mirror [0:NV*NV-1];
  logic [VC_W-1:0]     vc_mirror;
  logic [SRC_W-1:0]    src_mirror;

  int idle_pct       = 20;
  bit hold_ask       = 1'b0;
  int hold_cnt       = 0;
  int quiet_cycles   = 0;
  int errors         = 0;
  int entries_taken  = 0;
  int runs_solved    = 0;
  int results_seen   = 0;
  int unreached_seen = 0;
  int longest_seen   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dense_graph_shortest_paths i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .row          (row),
    .col          (col),
    .weight       (weight),
    .final_entry  (final_entry),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex       (vertex),
    .distance     (distance),
    .reachable    (reachable),
    .final_result (final_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic int active_count(input logic [VC_W-1:0] vc);
    if (vc < 2) return 2;
    if (vc > NV) return NV;
    return int'(vc);
  endfunction

  // single-source Dijkstra over the mirrored matrix; ties go to the highest index
  task automatic solve_from_source();
    int          n;
    int          u;
    int unsigned span [NV];
    bit          reach [NV];
    bit          done [NV];
    bit          have;
    bit          best_reach;
    int unsigned best_span;
    bit          take;
    int unsigned sum;
    path_t       res;
    n = active_count(vc_mirror);
    for (int i = 0; i < NV; i++) begin
      span[i]  = 0;
      reach[i] = 1'b0;
      done[i]  = 1'b0;
    end
    if (src_mirror < n) reach[src_mirror] = 1'b1;
    for (int rnd = 0; rnd < n - 1; rnd++) begin
      u = 0;
      have = 1'b0;
      best_reach = 1'b0;
      best_span = 0;
      for (int v = 0; v < n; v++) begin
        if (!done[v]) begin
          if (!have) take = 1'b1;
          else if (reach[v] != best_reach) take = reach[v];
          else take = !reach[v] || span[v] <= best_span;
          if (take) begin
            have = 1'b1;
            u = v;
            best_reach = reach[v];
            best_span = span[v];
          end
        end
      end
      done[u] = 1'b1;
      if (reach[u]) begin
        for (int v = 0; v < n; v++) begin
          if (!done[v] && weight_mirror[u*NV+v] != 0) begin
            sum = span[u] + weight_mirror[u*NV+v];
            if (!reach[v] || sum < span[v]) begin
              span[v] = sum;
              reach[v] = 1'b1;
            end
          end
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      res.vertex = v[VERTEX_W-1:0];
      if (!reach[v]) res.span = '0;
      else if (span[v] > DIST_MAX) res.span = DIST_MAX;
      else res.span = span[v][DIST_W-1:0];
      res.reach = reach[v];
      res.last = (v == n - 1);
      path_q.push_back(res);
    end
  endtask

  task automatic check_result();
    path_t want;
    if (path_q.size() == 0) begin
      $error("unexpected result for vertex %0d", vertex);
      errors++;
    end else begin
      want = path_q.pop_front();
      if (vertex !== want.vertex) begin
        $error("vertex: expected %0d, actual %0d", want.vertex, vertex);
        errors++;
      end
      if (distance !== want.span) begin
        $error("distance: expected %0d, actual %0d", want.span, distance);
        errors++;
      end
      if (reachable !== want.reach) begin
        $error("reachable: expected %0d, actual %0d", want.reach, reachable);
        errors++;
      end
      if (final_result !== want.last) begin
        $error("final_result: expected %0d, actual %0d", want.last, final_result);
        errors++;
      end
    end
    results_seen++;
    if (!reachable) unreached_seen++;
    if (int'(distance) > longest_seen) longest_seen = int'(distance);
  endtask

  // register and matrix mirrors, prediction on each accepted final entry, result check
  always @(posedge clk) begin
    if (rst) begin
      vc_mirror = VERTEX_COUNT_RST;
      src_mirror = SOURCE_VERTEX_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_VERTEX_COUNT) vc_mirror = cfg_data[VC_W-1:0];
        else if (cfg_index == REG_SOURCE_VERTEX) src_mirror = cfg_data[SRC_W-1:0];
      end
      if (in_valid && !in_stall) begin
        entries_taken++;
        weight_mirror[{row, col}] = weight;
        if (final_entry) begin
          solve_from_source();
          runs_solved++;
        end
      end
      if (out_valid && !out_stall) check_result();
    end
  end

  always @(posedge clk) begin : drive_entries
    entry_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (entry_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = entry_q.pop_front();
        in_valid    <= 1'b1;
        row         <= nxt.row;
        col         <= nxt.col;
        weight      <= nxt.weight;
        final_entry <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long hold starts at the first result seen after it is requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_ask && hold_cnt < HOLD_CYCLES && (hold_cnt != 0 || out_valid)) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_entry(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                            input logic [WEIGHT_W-1:0] w, input logic last);
    entry_t e;
    e.row = r;
    e.col = c;
    e.weight = w;
    e.last = last;
    entry_q.push_back(e);
  endtask

  task automatic push_random(input int n, input logic last);
    logic [ROW_W-1:0]    r;
    logic [COL_W-1:0]    c;
    logic [WEIGHT_W-1:0] w;
    r = ($urandom_range(4) == 0) ? ROW_W'($urandom_range(NV - 1))
                                 : ROW_W'($urandom_range(n - 1));
    c = ($urandom_range(4) == 0) ? COL_W'($urandom_range(NV - 1))
                                 : COL_W'($urandom_range(n - 1));
    case ($urandom_range(9))
      0, 1, 2, 3: w = '0;
      4, 5, 6:    w = WEIGHT_W'($urandom_range(1, 8));
      7, 8:       w = WEIGHT_W'($urandom_range(1, 16'hFFFF));
      default:    w = 16'hFFFF;
    endcase
    push_entry(r, c, w, last);
  endtask

  // drain: all items sent and every expected result taken
  task automatic wait_quiet();
    while (entry_q.size() != 0 || in_valid || path_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int               n_eff;
    int               runs;
    int               updates;
    int               phase_no;
    int               rand_items;
    logic [VC_W-1:0]  vc_pick;
    logic [CFG_DATA_W-1:0] src_pick;
    logic [WEIGHT_W-1:0]   w;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // two vertices, unknown register indexes ignored
    write_reg(REG_VERTEX_COUNT, 5'd2);
    write_reg(REG_SPARE_2, 5'd7);
    write_reg(REG_SPARE_3, 5'd31);
    push_entry(4'd0, 4'd0, 16'd0, 1'b0);
    push_entry(4'd0, 4'd1, 16'hFFFF, 1'b0);
    push_entry(4'd1, 4'd0, 16'd1, 1'b0);
    push_entry(4'd1, 4'd1, 16'd0, 1'b1);
    wait_quiet();

    // count below range acts as two; vertex 0 left unreachable
    write_reg(REG_VERTEX_COUNT, 5'd0);
    write_reg(REG_SOURCE_VERTEX, 5'd1);
    push_entry(4'd1, 4'd0, 16'd0, 1'b1);
    wait_quiet();

    // source outside the active vertices
    write_reg(REG_VERTEX_COUNT, 5'd1);
    write_reg(REG_SOURCE_VERTEX, 5'd31);
    push_entry(4'd0, 4'd1, 16'd5, 1'b1);
    wait_quiet();

    // equal distances: highest index selected first, strict-less relax
    write_reg(REG_VERTEX_COUNT, 5'd4);
    write_reg(REG_SOURCE_VERTEX, 5'd3);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        w = '0;
        if (r == 3 && c == 0) w = 16'd4;
        if (r == 3 && (c == 1 || c == 2)) w = 16'd2;
        if (r == 1 && c == 0) w = 16'd2;
        if (r == 2 && c == 0) w = 16'd1;
        if (r == 0 && c == 3) w = 16'd7;
        push_entry(r[ROW_W-1:0], c[COL_W-1:0], w, r == 3 && c == 3);
      end
    end
    push_entry(4'd2, 4'd0, 16'd0, 1'b1);
    wait_quiet();

    // full matrix, count above range acts as max; chain of max weights
    write_reg(REG_VERTEX_COUNT, 5'd31);
    write_reg(REG_SOURCE_VERTEX, 5'd0);
    idle_pct = 0;
    for (int r = 0; r < NV; r++) begin
      for (int c = 0; c < NV; c++) begin
        push_entry(r[ROW_W-1:0], c[COL_W-1:0], (c == r + 1) ? 16'hFFFF : 16'd0,
                   r == NV - 1 && c == NV - 1);
      end
    end
    wait_quiet();

    n_eff = NV;
    phase_no = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS || phase_no < 2) begin
      if (phase_no <= 2 || $urandom_range(1) == 0) begin
        if (phase_no == 1) vc_pick = 5'd16;
        else if (phase_no == 2) vc_pick = 5'd2;
        else if ($urandom_range(3) == 0) vc_pick = VC_W'($urandom_range(31));
        else vc_pick = VC_W'($urandom_range(2, 9));
        write_reg(REG_VERTEX_COUNT, vc_pick);
        n_eff = active_count(vc_pick);
        if (phase_no == 1) src_pick = 5'd15;
        else if ($urandom_range(4) == 0) src_pick = CFG_DATA_W'($urandom_range(31));
        else src_pick = CFG_DATA_W'($urandom_range(n_eff - 1));
        write_reg(REG_SOURCE_VERTEX, src_pick);
      end
      idle_pct = (phase_no >= 8 && phase_no < 12) ? 0 : 20;
      runs = $urandom_range(1, 3);
      if (phase_no == 1) begin
        hold_ask = 1'b1;
        runs = 3;
      end
      repeat (runs) begin
        updates = $urandom_range(0, 8);
        repeat (updates) push_random(n_eff, 1'b0);
        push_random(n_eff, 1'b1);
        rand_items += updates + 1;
      end
      wait_quiet();
      phase_no++;
    end

    wait_quiet();
    repeat (50) @(posedge clk);
    $display("Took %0d matrix entries over %0d runs; checked %0d vertex results",
             entries_taken, runs_solved, results_seen);
    $display("Unreachable results: %0d, longest distance: %0d", unreached_seen, longest_seen);
    if (errors == 0 && path_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dgsp_pkg.sv
rtl/dgsp_ctrl.sv
rtl/dgsp_datapath.sv
rtl/dense_graph_shortest_paths.sv
dv/tb_dense_graph_shortest_paths.sv
